// ===== rtl/core/alt_pkg.sv =====
// Package for the address list table: sizes, request modes, address classes.
// Used by the channel interfaces, the classifier and the top level.
package alt_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int WI_W        = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int MODE_W  = 2;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 6;
	localparam int CLASS_W = 3;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_SEARCH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INCLUDE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEER    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd3;

	// Address classes
	localparam logic [CLASS_W-1:0] CLS_PUBLIC   = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_NET10    = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_NET172   = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_NET192   = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_LINKLOC  = 3'd4;
	localparam logic [CLASS_W-1:0] CLS_LOOPBACK = 3'd5;
	localparam logic [CLASS_W-1:0] CLS_ZERO     = 3'd6;

	// Octet values
	localparam logic [7:0] OCT_10      = 8'd10;
	localparam logic [7:0] OCT_172     = 8'd172;
	localparam logic [7:0] OCT_16      = 8'd16;
	localparam logic [7:0] OCT_31      = 8'd31;
	localparam logic [7:0] OCT_192     = 8'd192;
	localparam logic [7:0] OCT_168     = 8'd168;
	localparam logic [7:0] OCT_169     = 8'd169;
	localparam logic [7:0] OCT_254     = 8'd254;
	localparam logic [7:0] OCT_127     = 8'd127;
	localparam logic [7:0] OCT_ZERO    = 8'd0;

endpackage

// ===== rtl/core/alt_req_if.sv =====
// Request channel of the address list table: valid, ready, mode and value.
// Depends on alt_pkg.
interface alt_req_if;
	import alt_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);

endinterface

// ===== rtl/core/alt_rsp_if.sv =====
// Result channel of the address list table: valid, ready and result fields.
// Depends on alt_pkg.
interface alt_rsp_if;
	import alt_pkg::*;

	logic               valid;
	logic               ready;
	logic               accepted;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] result_value;
	logic [CLASS_W-1:0] private_class;

	modport source (output valid, output accepted, output position, output result_value,
		output private_class, input ready);
	modport sink   (input valid, input accepted, input position, input result_value,
		input private_class, output ready);

endinterface

// ===== rtl/core/alt_class.sv =====
// Private-address classifier: maps the first two octets to a class code.
// Depends on alt_pkg.
module alt_class (
	input  logic [alt_pkg::VALUE_W-1:0] value,
	output logic [alt_pkg::CLASS_W-1:0] cls
);
	import alt_pkg::*;

	logic [7:0] oct0;
	logic [7:0] oct1;

	assign oct0 = value[7:0];
	assign oct1 = value[15:8];

	// Check the ranges in priority order
	always_comb begin
		priority if (oct0 == OCT_10) begin
			cls = CLS_NET10;
		end else if (oct0 == OCT_172 && oct1 >= OCT_16 && oct1 <= OCT_31) begin
			cls = CLS_NET172;
		end else if (oct0 == OCT_192 && oct1 == OCT_168) begin
			cls = CLS_NET192;
		end else if (oct0 == OCT_169 && oct1 == OCT_254) begin
			cls = CLS_LINKLOC;
		end else if (oct0 == OCT_127) begin
			cls = CLS_LOOPBACK;
		end else if (oct0 == OCT_ZERO) begin
			cls = CLS_ZERO;
		end else begin
			cls = CLS_PUBLIC;
		end
	end

endmodule

// ===== rtl/core/address_list_table.sv =====
// Address list table top level: sequencer, entry memory and result register.
// Depends on alt_pkg, alt_req_if, alt_rsp_if and alt_class.
//
//   channel   dir   payload                                         handshake
//   req       in    mode, value                                     valid/ready
//   rsp       out   accepted, position, result_value, private_class valid/ready
//   cfg       in    cfg_wdata (private_filter)                      cfg_we
//
// A request is taken only in the idle state. One compare unit walks the table
// slot by slot, reading each slot and then comparing it; a search ends at a match,
// an empty slot or the end of the table, and the result is then posted.
// A remove then compacts: each later slot is read and written one slot down,
// and at the end the last slot is cleared.
// After reset a clearing pass writes zero to all TABLE_DEPTH slots, one a cycle,
// before the first request is taken. A stalled result holds in the output
// register; the next request is taken meanwhile, but its result waits for it.
module address_list_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	alt_req_if.sink     req,
	alt_rsp_if.source   rsp
);
	import alt_pkg::*;

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_SRCH_RD  = 3'd2;
	localparam logic [2:0] ST_SRCH_CMP = 3'd3;
	localparam logic [2:0] ST_SHIFT_RD = 3'd4;
	localparam logic [2:0] ST_SHIFT_WR = 3'd5;
	localparam logic [2:0] ST_LAST     = 3'd6;
	localparam logic [2:0] ST_DONE     = 3'd7;

	localparam logic [WI_W-1:0] DEPTH_W = WI_W'(TABLE_DEPTH);
	localparam logic [WI_W-1:0] LAST_W  = WI_W'(TABLE_DEPTH - 1);

	logic [2:0]         state_q;
	logic [WI_W-1:0]    idx_q;
	logic [WI_W-1:0]    wi_q;
	logic               filter_q;
	logic [MODE_W-1:0]  mode_q;
	logic [VALUE_W-1:0] value_q;
	logic [CLASS_W-1:0] class_q;
	logic               acc_q;
	logic [WI_W-1:0]    pos_q;

	logic               rsp_valid_q;
	logic               rsp_acc_q;
	logic [POS_W-1:0]   rsp_pos_q;
	logic [VALUE_W-1:0] rsp_value_q;
	logic [CLASS_W-1:0] rsp_class_q;

	logic [VALUE_W-1:0] entries_q [TABLE_DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [IDX_W-1:0]   mem_raddr;

	logic [CLASS_W-1:0] req_class;
	logic [WI_W-1:0]    idx_inc;
	logic [WI_W-1:0]    wi_eff;
	logic               is_insert;
	logic               miss;
	logic               hit;
	logic               rsp_load;
	logic [WI_W+POS_W-1:0] pos_ext;

	alt_class u_class (
		.value (req.value),
		.cls   (req_class)
	);

	assign idx_inc   = idx_q + WI_W'(1);
	assign wi_eff    = (wi_q >= DEPTH_W) ? '0 : wi_q;
	assign is_insert = (mode_q == MODE_INCLUDE) || (mode_q == MODE_PEER);
	assign req.ready = (state_q == ST_IDLE);
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Shared compare unit: end of list, or a match at the current slot
	always_comb begin
		miss = 1'b0;
		hit  = 1'b0;
		if (state_q == ST_SRCH_RD) begin
			miss = (idx_q == DEPTH_W);
		end else if (state_q == ST_SRCH_CMP) begin
			miss = (rd_data_q == '0);
			hit  = !miss && (rd_data_q == value_q);
		end
	end

	// Drive the memory ports from the sequencer state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = '0;
		mem_raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_SRCH_RD, ST_SRCH_CMP: begin
				if (miss && is_insert) begin
					mem_we    = 1'b1;
					mem_waddr = wi_eff[IDX_W-1:0];
					mem_wdata = value_q;
				end
			end
			ST_SHIFT_RD: begin
				mem_raddr = idx_inc[IDX_W-1:0];
			end
			ST_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rd_data_q;
			end
			ST_LAST: begin
				mem_we    = 1'b1;
				mem_waddr = LAST_W[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Entry memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entries_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= entries_q[mem_raddr];
	end

	// Hold the private filter register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= 1'b0;
		end else if (cfg_we) begin
			filter_q <= cfg_wdata;
		end
	end

	// Request payload latched on accept
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			mode_q  <= req.mode;
			value_q <= req.value;
			class_q <= req_class;
		end
	end

	// Sequencer: clear, search, insert or compact, then post the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			wi_q    <= '0;
			acc_q   <= 1'b0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == LAST_W) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						idx_q <= '0;
						acc_q <= 1'b0;
						pos_q <= '0;
						if (req.value == '0 ||
							(req.mode == MODE_PEER && filter_q && req_class != CLS_PUBLIC)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SRCH_RD;
						end
					end
				end
				ST_SRCH_RD, ST_SRCH_CMP: begin
					if (miss) begin
						acc_q   <= is_insert;
						state_q <= ST_DONE;
						if (is_insert) begin
							pos_q <= wi_eff;
							wi_q  <= wi_eff + WI_W'(1);
						end
					end else if (hit) begin
						pos_q <= idx_q;
						if (mode_q == MODE_SEARCH) begin
							acc_q   <= 1'b1;
							state_q <= ST_DONE;
						end else if (mode_q == MODE_REMOVE) begin
							acc_q   <= 1'b1;
							state_q <= ST_SHIFT_RD;
							if (wi_q > idx_q) begin
								wi_q <= wi_q - WI_W'(1);
							end
						end else begin
							acc_q   <= 1'b0;
							state_q <= ST_DONE;
						end
					end else if (state_q == ST_SRCH_RD) begin
						state_q <= ST_SRCH_CMP;
					end else begin
						idx_q   <= idx_inc;
						state_q <= ST_SRCH_RD;
					end
				end
				ST_SHIFT_RD: begin
					if (idx_q >= LAST_W) begin
						state_q <= ST_LAST;
					end else begin
						state_q <= ST_SHIFT_WR;
					end
				end
				ST_SHIFT_WR: begin
					idx_q   <= idx_inc;
					state_q <= ST_SHIFT_RD;
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign pos_ext = {{POS_W{1'b0}}, pos_q};

	// Result register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_acc_q   <= acc_q;
			rsp_pos_q   <= acc_q ? pos_ext[POS_W-1:0] : '0;
			rsp_value_q <= acc_q ? value_q : '0;
			rsp_class_q <= class_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.accepted      = rsp_acc_q;
	assign rsp.position      = rsp_pos_q;
	assign rsp.result_value  = rsp_value_q;
	assign rsp.private_class = rsp_class_q;

endmodule

// ===== sim/address_list_table_tb.sv =====
// Testbench for address_list_table: directed and random search, include, add-peer and
// remove requests, each result checked against a behavioral copy of the address table.
// Depends on alt_pkg, alt_req_if, alt_rsp_if and the address_list_table RTL.
module address_list_table_tb;
	import alt_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 300;
	localparam int POOL_SIZE    = 100;
	localparam int PHASE_COUNT  = 7;
	localparam int PHASE_ITEMS  = 250;
	localparam int CALM_PHASE   = 3;
	localparam int IDLE_PERCENT = 19;

	typedef struct packed {
		logic               accepted;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] value;
		logic [CLASS_W-1:0] cls;
	} table_result_t;

	// Behavioral copy of the table, plus the results still owed by the block
	class addr_table_tracker;
		logic [VALUE_W-1:0] slots [TABLE_DEPTH];
		int unsigned        next_slot;
		logic               filter_on;
		table_result_t      awaited [$];
		int                 errors;

		function new();
			foreach (slots[k])
				slots[k] = '0;
			next_slot = 0;
			filter_on = 1'b0;
			errors    = 0;
		endfunction

		function logic [CLASS_W-1:0] classify(input logic [VALUE_W-1:0] v);
			logic [7:0] o0;
			logic [7:0] o1;
			o0 = v[7:0];
			o1 = v[15:8];
			if (o0 == OCT_10) return CLS_NET10;
			if (o0 == OCT_172 && o1 >= OCT_16 && o1 <= OCT_31) return CLS_NET172;
			if (o0 == OCT_192 && o1 == OCT_168) return CLS_NET192;
			if (o0 == OCT_169 && o1 == OCT_254) return CLS_LINKLOC;
			if (o0 == OCT_127) return CLS_LOOPBACK;
			if (o0 == OCT_ZERO) return CLS_ZERO;
			return CLS_PUBLIC;
		endfunction

		// Scan from slot 0, stop at the first empty slot
		function bit locate(input logic [VALUE_W-1:0] v, output int unsigned slot);
			slot = 0;
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				if (slots[k] == '0) return 1'b0;
				if (slots[k] == v) begin
					slot = k;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function bit insert_entry(input logic [VALUE_W-1:0] v, output int unsigned slot);
			int unsigned hit;
			slot = 0;
			if (v == '0 || locate(v, hit)) return 1'b0;
			// wrap the write index once it has run off the end
			if (next_slot >= TABLE_DEPTH) next_slot = 0;
			slot = next_slot;
			slots[next_slot] = v;
			next_slot++;
			return 1'b1;
		endfunction

		function bit remove_entry(input logic [VALUE_W-1:0] v, output int unsigned slot);
			if (!locate(v, slot)) return 1'b0;
			if (next_slot > slot) next_slot--;
			// shift later entries down and clear the last slot
			for (int k = slot; k < TABLE_DEPTH - 1; k++)
				slots[k] = slots[k + 1];
			slots[TABLE_DEPTH - 1] = '0;
			return 1'b1;
		endfunction

		function void note_request(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
			table_result_t r;
			int unsigned   slot;
			bit            ok;
			r.cls = classify(v);
			slot  = 0;
			ok    = 1'b0;
			case (m)
				MODE_SEARCH:  ok = locate(v, slot);
				MODE_INCLUDE: ok = insert_entry(v, slot);
				MODE_PEER: begin
					if (v != '0 && !(filter_on && r.cls != CLS_PUBLIC))
						ok = insert_entry(v, slot);
				end
				default:      ok = remove_entry(v, slot);
			endcase
			r.accepted = ok;
			r.position = ok ? POS_W'(slot) : '0;
			r.value    = ok ? v : '0;
			awaited.push_back(r);
		endfunction

		function void check_result(input logic acc, input logic [POS_W-1:0] pos,
				input logic [VALUE_W-1:0] val, input logic [CLASS_W-1:0] cls);
			table_result_t got;
			table_result_t want;
			got = '{acc, pos, val, cls};
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result acc=%0b pos=%0d value=%h class=%0d",
					$time, acc, pos, val, cls);
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: result mismatch: expected acc=%0b pos=%0d value=%h class=%0d",
					$time, want.accepted, want.position, want.value, want.cls);
				$display("%0t:                  actual   acc=%0b pos=%0d value=%h class=%0d",
					$time, acc, pos, val, cls);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	alt_req_if req_if ();
	alt_rsp_if rsp_if ();

	address_list_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	addr_table_tracker  tracker;
	logic [VALUE_W-1:0] addr_pool [POOL_SIZE];
	bit                 calm_stretch = 1'b0;
	int                 quiet_cycles = 0;

	always #10 clk = ~clk;

	// Take results and stall the result channel at random
	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready)
			tracker.check_result(rsp_if.accepted, rsp_if.position, rsp_if.result_value,
				rsp_if.private_class);
		rsp_if.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("address_list_table_tb: errors");
			$finish;
		end
	end

	// Present one request, idling first at random, and hold it until taken
	task automatic issue_request(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
		if (!calm_stretch && $urandom_range(99) < IDLE_PERCENT) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.mode  <= m;
		req_if.value <= v;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		tracker.note_request(m, v);
	endtask

	// Drop valid and wait until every owed result has come back
	task automatic drain_results();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic write_private_filter(input logic f);
		cfg_we    <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.filter_on = f;
	endtask

	function automatic logic [MODE_W-1:0] pick_mode(input int phase);
		int r;
		int s_pct;
		int i_pct;
		int p_pct;
		case (phase)
			1, 5: begin
				s_pct = 10; i_pct = 40; p_pct = 40;
			end
			2: begin
				s_pct = 10; i_pct = 45; p_pct = 35;
			end
			4: begin
				s_pct = 20; i_pct = 15; p_pct = 15;
			end
			default: begin
				s_pct = 25; i_pct = 25; p_pct = 25;
			end
		endcase
		r = $urandom_range(99);
		if (r < s_pct) return MODE_SEARCH;
		if (r < s_pct + i_pct) return MODE_INCLUDE;
		if (r < s_pct + i_pct + p_pct) return MODE_PEER;
		return MODE_REMOVE;
	endfunction

	// Mostly pooled addresses so that hits, duplicates and removes happen
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 4) return '0;
		if (r < 20) return $urandom;
		return addr_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	initial begin
		logic [VALUE_W-1:0] rnd;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		req_if.valid  = 1'b0;
		req_if.mode   = MODE_SEARCH;
		req_if.value  = '0;
		tracker = new();

		// Build the address pool with every private class among the random choices
		for (int k = 0; k < POOL_SIZE; k++) begin
			rnd = $urandom;
			case ($urandom_range(9))
				0: rnd[7:0] = OCT_10;
				1: begin
					rnd[7:0]  = OCT_172;
					rnd[15:8] = OCT_16 + 8'($urandom_range(15));
				end
				2: rnd[15:0] = {OCT_168, OCT_192};
				3: rnd[15:0] = {OCT_254, OCT_169};
				4: rnd[7:0]  = OCT_127;
				5: rnd[7:0]  = OCT_ZERO;
				default: ;
			endcase
			addr_pool[k] = rnd;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table, zero value, duplicates, removes with filter off
		issue_request(MODE_SEARCH,  32'h0102_0304);
		issue_request(MODE_SEARCH,  32'h0000_0000);
		issue_request(MODE_INCLUDE, 32'h0000_0000);
		issue_request(MODE_INCLUDE, 32'hFFFF_FFFF);
		issue_request(MODE_INCLUDE, 32'hFFFF_FFFF);
		issue_request(MODE_PEER,    32'h0000_000A);
		issue_request(MODE_SEARCH,  32'hFFFF_FFFF);
		issue_request(MODE_REMOVE,  32'h0000_0000);
		issue_request(MODE_REMOVE,  32'h1234_5678);
		issue_request(MODE_REMOVE,  32'hFFFF_FFFF);
		issue_request(MODE_SEARCH,  32'h0000_000A);

		// Filter on: each private class and the 172 range edges
		drain_results();
		write_private_filter(1'b1);
		issue_request(MODE_PEER,    32'h0000_000A);
		issue_request(MODE_PEER,    32'h0000_10AC);
		issue_request(MODE_PEER,    32'h0000_1FAC);
		issue_request(MODE_PEER,    32'h0000_20AC);
		issue_request(MODE_PEER,    32'h0000_A8C0);
		issue_request(MODE_PEER,    32'h0000_FEA9);
		issue_request(MODE_PEER,    32'h0100_007F);
		issue_request(MODE_PEER,    32'h0102_0300);
		issue_request(MODE_INCLUDE, 32'h0000_A8C0);
		issue_request(MODE_PEER,    32'h0000_0000);
		issue_request(MODE_PEER,    32'h0000_0FAC);

		// Random phases: vary the mix, toggle the filter, one phase with no idling
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			drain_results();
			write_private_filter(ph[0]);
			calm_stretch = (ph == CALM_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++)
				issue_request(pick_mode(ph), pick_value());
		end
		calm_stretch = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("address_list_table_tb: clean");
		end else begin
			$display("address_list_table_tb: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/alt_pkg.sv
rtl/core/alt_req_if.sv
rtl/core/alt_rsp_if.sv
rtl/core/alt_class.sv
rtl/core/address_list_table.sv
sim/address_list_table_tb.sv
